// ===== design/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
// No dependencies; imported by efr_core and escaped_frame_receiver_top.
package efr_pkg;

    localparam logic [7:0] MARK_BYTE  = 8'h10;
    localparam logic [7:0] OPEN_BYTE  = 8'h02;
    localparam logic [7:0] CLOSE_BYTE = 8'h03;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BADSUM  = 2'd2,
        KIND_BADESC  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  pos;
        logic [8:0]  len;
        logic        ovf;
    } efr_result_t;

endpackage

// ===== design/efr_core.sv =====
// Deframing state machine: frame phase, payload count, checksum, overflow flag.
// Depends on efr_pkg.
module efr_core #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output efr_pkg::efr_result_t res
);
    import efr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_DATA,
        PH_ESC,
        PH_SUM
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next, count_base;
    logic [7:0]         sum_reg, sum_next;
    logic               ovf_reg, ovf_next, ovf_base;
    logic               clear, keep, verdict;
    kind_t              vkind;

    always_comb begin
        phase_next = phase_reg;
        clear      = 1'b0;
        keep       = 1'b0;
        verdict    = 1'b0;
        vkind      = KIND_GOOD;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == MARK_BYTE) begin
                    phase_next = PH_OPEN;
                    clear      = 1'b1;
                end
            end
            PH_OPEN: begin
                phase_next = (rx_byte == OPEN_BYTE) ? PH_DATA : PH_IDLE;
            end
            PH_DATA: begin
                if (rx_byte == MARK_BYTE) begin
                    phase_next = PH_ESC;
                end else begin
                    keep = 1'b1;
                end
            end
            PH_ESC: begin
                if (rx_byte == MARK_BYTE) begin
                    phase_next = PH_DATA;
                    keep       = 1'b1;
                end else if (rx_byte == CLOSE_BYTE) begin
                    phase_next = PH_SUM;
                end else begin
                    phase_next = PH_IDLE;
                    verdict    = 1'b1;
                    vkind      = KIND_BADESC;
                end
            end
            PH_SUM: begin
                phase_next = PH_IDLE;
                verdict    = 1'b1;
                vkind      = (sum_reg == rx_byte) ? KIND_GOOD : KIND_BADSUM;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        count_base = clear ? '0 : count_reg;
        ovf_base   = clear ? 1'b0 : ovf_reg;
        sum_next   = (clear ? 8'h00 : sum_reg) + rx_byte;
        count_next = count_base;
        ovf_next   = ovf_base;

        res_valid = verdict;
        res.kind  = vkind;
        res.data  = '0;
        res.pos   = '0;
        res.len   = 9'(count_reg);
        res.ovf   = ovf_reg;

        if (keep) begin
            if (count_base < CNT_W'(MAX_FRAME_LEN)) begin
                res_valid  = 1'b1;
                res.kind   = KIND_PAYLOAD;
                res.data   = rx_byte;
                res.pos    = 8'(count_base);
                res.len    = '0;
                res.ovf    = 1'b0;
                count_next = count_base + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== design/escaped_frame_receiver_top.sv =====
// Top level of the escaped frame receiver: input register, deframer, result register.
// Depends on efr_pkg and efr_core.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_rx_byte[7:0]
//  m_      | out       | m_valid / m_ready  | m_result_kind, m_data_byte, m_byte_position,
//          |           |                    | m_frame_length, m_overflowed
//
// One byte per cycle sustained while m_ready is high; each byte's result is loaded
// into the result register from the input register through the deframer logic.
// The deframer steps whenever the input register is full and the result register
// is empty or being drained, so the only limit is m_ready backpressure.
// Synchronous active-low reset empties both registers and returns the phase to idle.
// A stall on m_ready holds the result and, one byte later, s_ready.
module escaped_frame_receiver_top #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_byte_position,
    output logic [8:0]  m_frame_length,
    output logic        m_overflowed
);
    import efr_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    efr_result_t out_res_reg;
    logic        step;
    logic        core_valid;
    efr_result_t core_res;

    // Process the held byte when the result slot is free or draining this cycle.
    assign step    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || step;

    efr_core #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step),
        .rx_byte  (in_byte_reg),
        .res_valid(core_valid),
        .res      (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (step) begin
                in_vld_reg <= 1'b0;
            end
            if (step) begin
                out_vld_reg <= core_valid;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step && core_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_result_kind   = out_res_reg.kind;
    assign m_data_byte     = out_res_reg.data;
    assign m_byte_position = out_res_reg.pos;
    assign m_frame_length  = out_res_reg.len;
    assign m_overflowed    = out_res_reg.ovf;

`ifndef ASSERT_OFF
    a_payload_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_PAYLOAD) |-> (m_frame_length == 9'd0 && !m_overflowed))
        else $error("payload transfer carries verdict fields");

    a_verdict_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_PAYLOAD) |-> (m_data_byte == 8'd0 && m_byte_position == 8'd0))
        else $error("verdict transfer carries payload fields");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("input stalled with empty input register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("registers not empty after reset");
`endif

endmodule
